/* rtl/dtt_pkg.sv */
package dtt_pkg;

  typedef enum logic [2:0] {
    OP_ADD         = 3'd0,
    OP_ADD_SINGLE  = 3'd1,
    OP_DEL_SLOT    = 3'd2,
    OP_DEL_HANDLER = 3'd3,
    OP_DEL_ALL     = 3'd4,
    OP_DISPATCH    = 3'd5,
    OP_QUERY_TIME  = 3'd6,
    OP_ELAPSE      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_WAIT  = 2'd1,
    ST_READY = 2'd2
  } entry_st_e;

  localparam int unsigned HandlerBits = 32;
  localparam int unsigned ParamBits   = 32;
  localparam int unsigned SlotBits    = 4;
  localparam int unsigned ValueBits   = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic elapse;     // apply elapsed time to the visited slot
    logic del_hdl;    // delete the visited slot if its handler matches
    logic find_free;  // look for the first free slot
    logic disp;       // dispatch the visited slot if ready, track nearest
    logic clr_all;    // free the visited slot, keep handler and param
    logic del_slot;   // delete the addressed slot on handler match
    logic write_add;  // write the new entry into the found free slot
    logic query;      // capture the countdown of the addressed slot
    logic emit;       // present the visited entry as a dispatched item
    logic status;     // present the status item
    logic idx_clr;    // restart the scan index
    logic idx_inc;    // advance the scan index
  } dtt_cmd_t;

  typedef struct packed {
    logic idx_last;   // scan index at the last slot
    logic free_found; // a free slot was found
    logic vis_ready;  // visited slot is ready
    logic out_busy;   // output register full and not taken
    op_e  op;
  } dtt_sts_t;

endpackage

/* rtl/dtt_ctrl.sv */
module dtt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  dtt_pkg::dtt_sts_t sts_i,
  output dtt_pkg::dtt_cmd_t cmd_o
);
  import dtt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELH,
    S_FIND,
    S_ELAPSE,
    S_APPLY,
    S_DISP,
    S_STATUS
  } state_e;

  state_e state_q, state_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = S_DELH;
        end
      end
      S_DELH: begin
        if (sts_i.op == OP_ADD_SINGLE || sts_i.op == OP_DEL_HANDLER) begin
          cmd_o.del_hdl = 1'b1;
          cmd_o.idx_inc = 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.idx_clr = 1'b1;
            state_d = (sts_i.op == OP_ADD_SINGLE) ? S_FIND : S_STATUS;
          end
        end else if (sts_i.op == OP_ADD) begin
          state_d = S_FIND;
        end else if (sts_i.op == OP_DEL_ALL) begin
          cmd_o.clr_all = 1'b1;
          cmd_o.idx_inc = 1'b1;
          if (sts_i.idx_last) state_d = S_STATUS;
        end else if (sts_i.op == OP_DEL_SLOT) begin
          cmd_o.del_slot = 1'b1;
          state_d        = S_STATUS;
        end else begin
          state_d = S_ELAPSE;
        end
      end
      S_FIND: begin
        cmd_o.find_free = 1'b1;
        cmd_o.idx_inc   = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_ELAPSE;
        end
      end
      S_ELAPSE: begin
        if ((sts_i.op == OP_ADD || sts_i.op == OP_ADD_SINGLE) && !sts_i.free_found) begin
          state_d = S_STATUS;
        end else begin
          cmd_o.elapse  = 1'b1;
          cmd_o.idx_inc = 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        if (sts_i.op == OP_ADD || sts_i.op == OP_ADD_SINGLE) begin
          cmd_o.write_add = 1'b1;
          state_d         = S_STATUS;
        end else if (sts_i.op == OP_QUERY_TIME) begin
          cmd_o.query = 1'b1;
          state_d     = S_STATUS;
        end else if (sts_i.op == OP_DISPATCH) begin
          state_d = S_DISP;
        end else begin
          state_d = S_STATUS;
        end
      end
      S_DISP: begin
        if (!(sts_i.vis_ready && sts_i.out_busy)) begin
          cmd_o.disp    = 1'b1;
          cmd_o.emit    = sts_i.vis_ready;
          cmd_o.idx_inc = 1'b1;
          if (sts_i.idx_last) state_d = S_STATUS;
        end
      end
      S_STATUS: begin
        if (!sts_i.out_busy) begin
          cmd_o.status = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/dtt_dpath.sv */
module dtt_dpath #(
  parameter int unsigned TaskSlots = 16,
  parameter int unsigned TimeBits  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dtt_pkg::dtt_cmd_t                 cmd_i,
  output dtt_pkg::dtt_sts_t                 sts_o,
  input  logic [2:0]                        in_op_i,
  input  logic [dtt_pkg::HandlerBits-1:0]   in_handler_i,
  input  logic [dtt_pkg::ParamBits-1:0]     in_param_i,
  input  logic [31:0]                       in_delay_i,
  input  logic [dtt_pkg::SlotBits-1:0]      in_slot_i,
  input  logic [31:0]                       in_elapsed_i,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic                              out_kind_o,
  output logic [dtt_pkg::SlotBits-1:0]      out_slot_o,
  output logic [dtt_pkg::HandlerBits-1:0]   out_handler_o,
  output logic [dtt_pkg::ParamBits-1:0]     out_param_o,
  output logic [dtt_pkg::ValueBits-1:0]     out_value_o,
  output logic                              out_last_o
);
  import dtt_pkg::*;

  localparam int unsigned IdxBits = $clog2(TaskSlots);
  localparam int unsigned CntBits = $clog2(TaskSlots + 1);
  localparam int unsigned InBits  = (TimeBits < 32) ? TimeBits : 32;

  entry_st_e              st_q  [TaskSlots];
  logic [HandlerBits-1:0] hdl_q [TaskSlots];
  logic [ParamBits-1:0]   par_q [TaskSlots];
  logic [TimeBits-1:0]    cnt_q [TaskSlots];

  op_e                    op_q;
  logic [HandlerBits-1:0] h_q;
  logic [ParamBits-1:0]   p_q;
  logic [TimeBits-1:0]    dly_q, el_q, near_q, qry_q;
  logic [SlotBits-1:0]    s_q;
  logic [IdxBits-1:0]     idx_q, free_q;
  logic                   found_q;
  logic [CntBits-1:0]     ndel_q;
  logic                   dslot_ok_q;

  logic [IdxBits-1:0]     sidx;
  logic                   s_in_range;
  logic [TimeBits-1:0]    dec;

  assign s_in_range = ({{(32-SlotBits){1'b0}}, s_q} < TaskSlots);
  assign sidx       = IdxBits'(s_q);
  assign dec        = (cnt_q[idx_q] > el_q) ? cnt_q[idx_q] - el_q : '0;

  assign sts_o.idx_last   = (idx_q == IdxBits'(TaskSlots - 1));
  assign sts_o.free_found = found_q;
  assign sts_o.vis_ready  = (st_q[idx_q] == ST_READY);
  assign sts_o.out_busy   = m_valid_o && !m_ready_i;
  assign sts_o.op         = op_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(in_op_i);
      h_q   <= in_handler_i;
      p_q   <= in_param_i;
      dly_q <= TimeBits'({{(TimeBits > 32 ? TimeBits - 32 : 1){1'b0}}, in_delay_i[InBits-1:0]});
      el_q  <= TimeBits'({{(TimeBits > 32 ? TimeBits - 32 : 1){1'b0}}, in_elapsed_i[InBits-1:0]});
      s_q   <= in_slot_i;
    end
    if (cmd_i.query) qry_q <= s_in_range ? cnt_q[sidx] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TaskSlots; i++) begin
        st_q[i]  <= ST_FREE;
        hdl_q[i] <= '0;
        par_q[i] <= '0;
        cnt_q[i] <= '0;
      end
      idx_q      <= '0;
      free_q     <= '0;
      found_q    <= 1'b0;
      ndel_q     <= '0;
      dslot_ok_q <= 1'b0;
      near_q     <= '1;
    end else begin
      if (cmd_i.load) begin
        found_q    <= 1'b0;
        ndel_q     <= '0;
        dslot_ok_q <= 1'b0;
        near_q     <= '1;
      end
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + 1'b1;

      if (cmd_i.del_hdl && st_q[idx_q] != ST_FREE && hdl_q[idx_q] == h_q) begin
        st_q[idx_q]  <= ST_FREE;
        hdl_q[idx_q] <= '0;
        par_q[idx_q] <= '0;
        cnt_q[idx_q] <= '0;
        ndel_q       <= ndel_q + 1'b1;
      end
      if (cmd_i.clr_all) begin
        st_q[idx_q]  <= ST_FREE;
        cnt_q[idx_q] <= '0;
      end
      if (cmd_i.find_free && !found_q && st_q[idx_q] == ST_FREE) begin
        found_q <= 1'b1;
        free_q  <= idx_q;
      end
      if (cmd_i.elapse && el_q != '0 && st_q[idx_q] == ST_WAIT) begin
        cnt_q[idx_q] <= dec;
        if (dec == '0 && hdl_q[idx_q] != '0) st_q[idx_q] <= ST_READY;
      end
      if (cmd_i.del_slot && s_in_range && hdl_q[sidx] == h_q) begin
        st_q[sidx]  <= ST_FREE;
        hdl_q[sidx] <= '0;
        par_q[sidx] <= '0;
        cnt_q[sidx] <= '0;
        dslot_ok_q  <= 1'b1;
      end
      if (cmd_i.write_add) begin
        hdl_q[free_q] <= h_q;
        par_q[free_q] <= p_q;
        cnt_q[free_q] <= dly_q;
        st_q[free_q]  <= (dly_q == '0) ? ST_READY : ST_WAIT;
      end
      if (cmd_i.disp) begin
        if (st_q[idx_q] == ST_READY) st_q[idx_q] <= ST_FREE;
        if (st_q[idx_q] == ST_WAIT && cnt_q[idx_q] < near_q) near_q <= cnt_q[idx_q];
      end
    end
  end

  logic [ValueBits-1:0] stat_val;
  always_comb begin
    case (op_q)
      OP_ADD, OP_ADD_SINGLE:
        stat_val = found_q ? ValueBits'(free_q) : ValueBits'(TaskSlots);
      OP_DEL_SLOT:    stat_val = ValueBits'(dslot_ok_q);
      OP_DEL_HANDLER: stat_val = ValueBits'(ndel_q);
      OP_DISPATCH:    stat_val = ValueBits'(near_q);
      OP_QUERY_TIME:  stat_val = ValueBits'(qry_q);
      default:        stat_val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_o <= 1'b0;
    end else if (cmd_i.emit || cmd_i.status) begin
      m_valid_o <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_o    <= 1'b1;
      out_slot_o    <= SlotBits'(idx_q);
      out_handler_o <= hdl_q[idx_q];
      out_param_o   <= par_q[idx_q];
      out_value_o   <= '0;
      out_last_o    <= 1'b0;
    end else if (cmd_i.status) begin
      out_kind_o    <= 1'b0;
      out_slot_o    <= '0;
      out_handler_o <= '0;
      out_param_o   <= '0;
      out_value_o   <= stat_val;
      out_last_o    <= 1'b1;
    end
  end

endmodule

/* rtl/delayed_task_table_unit.sv */
// Delayed task table: TASK_SLOTS entries held in registers and walked by a
// controller, one slot per cycle while the output register does not stall a
// dispatch scan. Each scan of the table (delete by handler, delete all,
// free-slot search, elapse, dispatch) visits every slot: add_single runs
// three scans, add, dispatch and delete by handler two or fewer, and delete
// by slot none. Dispatch also waits on the output register for every emitted
// task, and every item waits for a full output register to drain before its
// status item goes out. One item is worked at a time.
module delayed_task_table_unit #(
  parameter int unsigned TASK_SLOTS = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [135:0]   s_axis_tdata,  // op, handler_tag, task_param, delay, slot, elapsed
  input  logic           m_axis_tready,
  output logic           m_axis_tvalid,
  output logic [103:0]   m_axis_tdata,  // out_slot, out_handler, out_param, value
  output logic           m_axis_tuser,  // kind
  output logic           m_axis_tlast   // last
);
  import dtt_pkg::*;

  dtt_cmd_t cmd;
  dtt_sts_t sts;
  logic [3:0]  o_slot;
  logic [31:0] o_hdl, o_par, o_val;

  dtt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dtt_dpath #(
    .TaskSlots (TASK_SLOTS),
    .TimeBits  (TIME_BITS)
  ) u_dpath (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_op_i       (s_axis_tdata[2:0]),
    .in_handler_i  (s_axis_tdata[34:3]),
    .in_param_i    (s_axis_tdata[66:35]),
    .in_delay_i    (s_axis_tdata[98:67]),
    .in_slot_i     (s_axis_tdata[102:99]),
    .in_elapsed_i  (s_axis_tdata[134:103]),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .out_kind_o    (m_axis_tuser),
    .out_slot_o    (o_slot),
    .out_handler_o (o_hdl),
    .out_param_o   (o_par),
    .out_value_o   (o_val),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, o_val, o_par, o_hdl, o_slot};

endmodule

/* rtl/dtt_checker.sv */
module dtt_sva_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast,
  input logic [103:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_kind_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != m_axis_tlast))
    else $error("dispatched item marked last or status not last");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a second item while busy");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[67:0] == '0)
    else $error("status item carries task fields");

endmodule

bind delayed_task_table_unit dtt_sva_checker u_dtt_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tuser, .m_axis_tlast, .m_axis_tdata
);

/* dv/dtt_checker.sv */
`timescale 1ns / 100ps
module dtt_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [135:0] in_data_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic [103:0] out_data_i,
  input  logic         out_user_i,
  input  logic         out_last_i,
  output int           fail_count_o,
  output int           pending_o
);
  import dtt_pkg::*;

  localparam int Slots = 16;

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [31:0] handler;
    logic [31:0] param;
    logic [31:0] value;
    logic        last;
  } task_res_t;

  entry_st_e   tbl_st  [Slots];
  logic [31:0] tbl_hdl [Slots];
  logic [31:0] tbl_par [Slots];
  logic [31:0] tbl_cnt [Slots];
  task_res_t   expected_q[$];

  assign pending_o = expected_q.size();

  function automatic void recount(input logic [31:0] el);
    if (el != 0) begin
      for (int i = 0; i < Slots; i++) begin
        if (tbl_st[i] == ST_WAIT) begin
          tbl_cnt[i] = (tbl_cnt[i] > el) ? tbl_cnt[i] - el : '0;
          if (tbl_cnt[i] == 0 && tbl_hdl[i] != 0) tbl_st[i] = ST_READY;
        end
      end
    end
  endfunction

  function automatic void clear_slot(input int i);
    tbl_st[i] = ST_FREE;
    tbl_hdl[i] = '0;
    tbl_par[i] = '0;
    tbl_cnt[i] = '0;
  endfunction

  function automatic logic [31:0] drop_handler(input logic [31:0] h);
    logic [31:0] n;
    n = 0;
    for (int i = 0; i < Slots; i++) begin
      if (tbl_st[i] != ST_FREE && tbl_hdl[i] == h) begin
        clear_slot(i);
        n++;
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] insert_task(input logic [31:0] h, p, d, el);
    int f;
    f = -1;
    for (int i = Slots - 1; i >= 0; i--) if (tbl_st[i] == ST_FREE) f = i;
    if (f < 0) return Slots;
    recount(el);
    tbl_hdl[f] = h;
    tbl_par[f] = p;
    tbl_cnt[f] = d;
    tbl_st[f] = (d != 0) ? ST_WAIT : ST_READY;
    return f;
  endfunction

  task automatic predict_item(input logic [135:0] d);
    op_e         op;
    logic [31:0] h, p, dl, el, v, n;
    logic [3:0]  s;
    task_res_t   r;
    op = op_e'(d[2:0]);
    h  = d[34:3];
    p  = d[66:35];
    dl = d[98:67];
    s  = d[102:99];
    el = d[134:103];
    v  = 0;
    case (op)
      OP_ADD: v = insert_task(h, p, dl, el);
      OP_ADD_SINGLE: begin
        n = drop_handler(h);
        v = insert_task(h, p, dl, el);
      end
      OP_DEL_SLOT: begin
        if (tbl_hdl[s] == h) begin
          clear_slot(s);
          v = 1;
        end
      end
      OP_DEL_HANDLER: v = drop_handler(h);
      OP_DEL_ALL: begin
        for (int i = 0; i < Slots; i++) begin
          tbl_st[i] = ST_FREE;
          tbl_cnt[i] = '0;
        end
      end
      OP_DISPATCH: begin
        recount(el);
        for (int i = 0; i < Slots; i++) begin
          if (tbl_st[i] == ST_READY) begin
            r = '{1'b1, 4'(i), tbl_hdl[i], tbl_par[i], 32'd0, 1'b0};
            expected_q.push_back(r);
            tbl_st[i] = ST_FREE;
          end
        end
        v = '1;
        for (int i = 0; i < Slots; i++)
          if (tbl_st[i] == ST_WAIT && tbl_cnt[i] < v) v = tbl_cnt[i];
      end
      OP_QUERY_TIME: begin
        recount(el);
        v = tbl_cnt[s];
      end
      default: recount(el);
    endcase
    r = '{1'b0, 4'd0, 32'd0, 32'd0, v, 1'b1};
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    fail_count_o++;
  endtask

  task automatic compare_result();
    task_res_t e;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected item", out_data_i[31:0], 0);
      return;
    end
    e = expected_q.pop_front();
    if (out_user_i != e.kind) report_mismatch("kind", out_user_i, e.kind);
    if (out_data_i[3:0] != e.slot) report_mismatch("slot", out_data_i[3:0], e.slot);
    if (out_data_i[35:4] != e.handler) report_mismatch("handler", out_data_i[35:4], e.handler);
    if (out_data_i[67:36] != e.param) report_mismatch("param", out_data_i[67:36], e.param);
    if (out_data_i[99:68] != e.value) report_mismatch("value", out_data_i[99:68], e.value);
    if (out_last_i != e.last) report_mismatch("last", out_last_i, e.last);
  endtask

  initial begin
    fail_count_o = 0;
    for (int i = 0; i < Slots; i++) clear_slot(i);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) compare_result();
      if (in_valid_i && in_ready_i) predict_item(in_data_i);
    end
  end
endmodule

/* dv/tb_delayed_task_table_unit.sv */
`timescale 1ns / 100ps
module tb_delayed_task_table_unit;
  import dtt_pkg::*;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tready = 0;
  logic         m_axis_tvalid;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  int           fail_count;
  int           pending;
  int           idle_cycles;
  logic [31:0]  handler_pool [4];
  bit           hold_off = 0;

  delayed_task_table_unit dut (.*);

  dtt_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready), .in_data_i(s_axis_tdata),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_i(m_axis_tdata), .out_user_i(m_axis_tuser), .out_last_i(m_axis_tlast),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial forever #5 clk_i = ~clk_i;

  function automatic logic [135:0] pack_item(op_e op, logic [31:0] h, p, d,
                                             logic [3:0] s, logic [31:0] el);
    return {1'b0, el, s, d, p, h, op};
  endfunction

  task automatic send(input logic [135:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic pause_sender();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return $urandom_range(1, 20);
      2: return '1;
      3: return $urandom_range(1, 200);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [135:0] rand_item();
    op_e         op;
    logic [31:0] h;
    int          w;
    w = $urandom_range(0, 99);
    if (w < 30) op = OP_ADD;
    else if (w < 40) op = OP_ADD_SINGLE;
    else if (w < 48) op = OP_DEL_SLOT;
    else if (w < 55) op = OP_DEL_HANDLER;
    else if (w < 58) op = OP_DEL_ALL;
    else if (w < 75) op = OP_DISPATCH;
    else if (w < 85) op = OP_QUERY_TIME;
    else op = OP_ELAPSE;
    h = $urandom_range(0, 9) == 0 ? $urandom : handler_pool[$urandom_range(0, 3)];
    return pack_item(op, h, $urandom, rand_time(), 4'($urandom), rand_time());
  endfunction

  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("** delayed_task_table_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int n;
    idle_cycles = 0;
    handler_pool = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h5A5A_A5A5};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(pack_item(OP_ADD, 32'd0, 32'd7, 32'd0, 4'd0, 32'd0));
    send(pack_item(OP_ADD, 32'd0, 32'd8, 32'd5, 4'd0, 32'd0));
    send(pack_item(OP_ADD, '1, '1, '1, 4'd15, '1));
    send(pack_item(OP_ADD, 32'd1, 32'd2, 32'd3, 4'd0, 32'd0));
    send(pack_item(OP_QUERY_TIME, 32'd0, 32'd0, 32'd0, 4'd3, 32'd1));
    send(pack_item(OP_DISPATCH, 32'd0, 32'd0, 32'd0, 4'd0, 32'd10));
    send(pack_item(OP_ADD_SINGLE, 32'd1, 32'd9, 32'd4, 4'd0, 32'd0));
    send(pack_item(OP_ADD_SINGLE, 32'd1, 32'd9, 32'd0, 4'd0, 32'd0));
    send(pack_item(OP_DEL_SLOT, 32'd0, 32'd0, 32'd0, 4'd5, 32'd0));
    send(pack_item(OP_DEL_SLOT, 32'd1, 32'd0, 32'd0, 4'd1, 32'd0));
    send(pack_item(OP_DEL_HANDLER, '1, 32'd0, 32'd0, 4'd0, 32'd0));
    for (int i = 0; i < 17; i++)
      send(pack_item(OP_ADD, 32'd1, i, 32'd2, 4'd0, 32'd0));
    send(pack_item(OP_DISPATCH, 32'd0, 32'd0, 32'd0, 4'd0, 32'd1));
    send(pack_item(OP_DEL_ALL, 32'd0, 32'd0, 32'd0, 4'd0, '1));
    send(pack_item(OP_ELAPSE, 32'd0, 32'd0, 32'd0, 4'd0, '1));
    send(pack_item(OP_DISPATCH, 32'd0, 32'd0, 32'd0, 4'd0, 32'd0));
    hold_off = 1;
    fork
      begin
        for (int i = 0; i < 16; i++)
          send(pack_item(OP_ADD, 32'd3, i, 32'd0, 4'd0, 32'd0));
        send(pack_item(OP_DISPATCH, 32'd0, 32'd0, 32'd0, 4'd0, 32'd0));
      end
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
    join
    n = 0;
    while (n < 330) begin
      if ($urandom_range(0, 9) == 0) handler_pool[$urandom_range(1, 3)] = $urandom;
      pause_sender();
      send(rand_item());
      n++;
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("** delayed_task_table_unit: PASSED **");
    else $display("** delayed_task_table_unit: FAILED **");
    $finish;
  end
endmodule
